// File: rtl/core/trs_pkg.sv
// ----------------------------------------------------------------------------
// trs_pkg
// shared types and constants for the transform matrix builder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trs_pkg;

  localparam int IN_W           = 32;
  localparam int CW             = 34;   // cordic x/y, q2.30 with headroom
  localparam int ZW             = 26;   // cordic angle, signed q10.16 degrees
  localparam int ITERS_PER_STEP = 4;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  // floor(v / 360) = (v * RECIP_360) >> RECIP_SHIFT for v below 2**25
  localparam logic [25:0] RECIP_360   = 26'd47721859;
  localparam int          RECIP_SHIFT = 34;

  typedef logic signed [ZW-1:0] angle_t;

  localparam angle_t DEG90  = angle_t'(90 * 65536);
  localparam angle_t DEG180 = angle_t'(180 * 65536);
  localparam angle_t DEG270 = angle_t'(270 * 65536);
  localparam angle_t DEG360 = angle_t'(360 * 65536);

  typedef enum logic [1:0] {
    ROW_0,
    ROW_1,
    ROW_2,
    ROW_3
  } row_t;

  // one transform as it leaves the cordic, before rounding
  typedef struct packed {
    logic [2:0]                neg;
    logic signed [CW-1:0]      cos_x;
    logic signed [CW-1:0]      sin_x;
    logic signed [CW-1:0]      cos_y;
    logic signed [CW-1:0]      sin_y;
    logic signed [CW-1:0]      cos_z;
    logic signed [CW-1:0]      sin_z;
    logic signed [IN_W-1:0]    pos_x;
    logic signed [IN_W-1:0]    pos_y;
    logic signed [IN_W-1:0]    pos_z;
    logic signed [IN_W-1:0]    scale_x;
    logic signed [IN_W-1:0]    scale_y;
    logic signed [IN_W-1:0]    scale_z;
  } trs_entry_t;

  // arctangent of 2**-i in signed q10.16 degrees
  function automatic angle_t atan_deg(input logic [3:0] idx);
    case (idx)
      4'd0:    atan_deg = angle_t'(2949120);
      4'd1:    atan_deg = angle_t'(1740967);
      4'd2:    atan_deg = angle_t'(919879);
      4'd3:    atan_deg = angle_t'(466945);
      4'd4:    atan_deg = angle_t'(234379);
      4'd5:    atan_deg = angle_t'(117304);
      4'd6:    atan_deg = angle_t'(58666);
      4'd7:    atan_deg = angle_t'(29335);
      4'd8:    atan_deg = angle_t'(14668);
      4'd9:    atan_deg = angle_t'(7334);
      4'd10:   atan_deg = angle_t'(3667);
      4'd11:   atan_deg = angle_t'(1833);
      4'd12:   atan_deg = angle_t'(917);
      4'd13:   atan_deg = angle_t'(458);
      4'd14:   atan_deg = angle_t'(229);
      4'd15:   atan_deg = angle_t'(115);
      default: atan_deg = '0;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/trs_front.sv
// ----------------------------------------------------------------------------
// trs_front
// angle reduction and three-lane cordic, four iterations per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trs_front import trs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [IN_W-1:0] pos_x,
  input  logic signed [IN_W-1:0] pos_y,
  input  logic signed [IN_W-1:0] pos_z,
  input  logic signed [IN_W-1:0] angle_x,
  input  logic signed [IN_W-1:0] angle_y,
  input  logic signed [IN_W-1:0] angle_z,
  input  logic signed [IN_W-1:0] scale_x,
  input  logic signed [IN_W-1:0] scale_y,
  input  logic signed [IN_W-1:0] scale_z,
  output logic                   push,
  output trs_entry_t             push_data,
  input  logic                   q_full
);

  localparam int VW   = 25;
  localparam int PW   = VW + 26;
  localparam int QW   = 17;
  // multiple of 360 that lifts every whole-degree part above zero
  localparam int K360 = ((2 ** (IN_W - 1 - FRAC_BITS) + 359) / 360) * 360;

  typedef struct packed {
    logic signed [IN_W-1:0] pos_x;
    logic signed [IN_W-1:0] pos_y;
    logic signed [IN_W-1:0] pos_z;
    logic signed [IN_W-1:0] scale_x;
    logic signed [IN_W-1:0] scale_y;
    logic signed [IN_W-1:0] scale_z;
  } carry_t;

  logic signed [IN_W-1:0] ang [3];
  logic [15:0]            frac16 [3];
  logic [VW-1:0]          whole [3];

  logic          s1_v;
  logic [VW-1:0] s1_whole [3];
  logic [15:0]   s1_frac [3];
  carry_t        s1_carry;

  logic          s2_v;
  logic [VW-1:0] s2_whole [3];
  logic [PW-1:0] s2_prod [3];
  logic [15:0]   s2_frac [3];
  carry_t        s2_carry;

  logic                 c_v;
  logic [1:0]           c_cnt;
  logic signed [CW-1:0] c_x [3];
  logic signed [CW-1:0] c_y [3];
  angle_t               c_z [3];
  logic [2:0]           c_neg;
  carry_t               c_carry;

  logic signed [CW-1:0] nx [3];
  logic signed [CW-1:0] ny [3];
  angle_t               nz [3];
  angle_t               zl [3];
  logic [2:0]           nl;

  logic c_load_ok, s2_ok, s1_ok;

  assign ang[0] = angle_x;
  assign ang[1] = angle_y;
  assign ang[2] = angle_z;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [IN_W:0] wide;
    assign wide     = ($signed({ang[l][IN_W-1], ang[l]}) >>> FRAC_BITS)
                      + (IN_W + 1)'(K360);
    assign whole[l] = wide[VW-1:0];
    if (FRAC_BITS >= 16) begin : g_trunc
      assign frac16[l] = ang[l][FRAC_BITS-1 -: 16];
    end else begin : g_pad
      assign frac16[l] = {ang[l][FRAC_BITS-1:0], {(16 - FRAC_BITS){1'b0}}};
    end
  end

  assign push      = c_v && (c_cnt == 2'd3) && !q_full;
  assign c_load_ok = !c_v || push;
  assign s2_ok     = !s2_v || c_load_ok;
  assign s1_ok     = !s1_v || s2_ok;
  assign in_stall  = !s1_ok;

  // remainder mod 360 and fold into the cordic range
  always_comb begin : p_fold
    logic [QW-1:0] q;
    logic [VW-1:0] q360;
    logic [VW-1:0] rem;
    angle_t        z;
    for (int l = 0; l < 3; l++) begin
      q     = s2_prod[l][RECIP_SHIFT +: QW];
      q360  = VW'(q) * VW'(360);
      rem   = s2_whole[l] - q360;
      z     = $signed({1'b0, rem[8:0], s2_frac[l]});
      nl[l] = 1'b0;
      if (z > DEG90 && z < DEG270) begin
        z     = z - DEG180;
        nl[l] = 1'b1;
      end else if (z >= DEG270) begin
        z = z - DEG360;
      end
      zl[l] = z;
    end
  end

  always_comb begin : p_cordic
    logic signed [CW-1:0] xt, yt, dx, dy;
    angle_t               zt;
    logic [3:0]           idx;
    for (int l = 0; l < 3; l++) begin
      xt = c_x[l];
      yt = c_y[l];
      zt = c_z[l];
      for (int k = 0; k < ITERS_PER_STEP; k++) begin
        idx = {c_cnt, 2'(k)};
        dx  = yt >>> idx;
        dy  = xt >>> idx;
        if (zt >= 0) begin
          xt = xt - dx;
          yt = yt + dy;
          zt = zt - atan_deg(idx);
        end else begin
          xt = xt + dx;
          yt = yt - dy;
          zt = zt + atan_deg(idx);
        end
      end
      nx[l] = xt;
      ny[l] = yt;
      nz[l] = zt;
    end
  end

  always_comb begin
    push_data.neg     = c_neg;
    push_data.cos_x   = nx[0];
    push_data.sin_x   = ny[0];
    push_data.cos_y   = nx[1];
    push_data.sin_y   = ny[1];
    push_data.cos_z   = nx[2];
    push_data.sin_z   = ny[2];
    push_data.pos_x   = c_carry.pos_x;
    push_data.pos_y   = c_carry.pos_y;
    push_data.pos_z   = c_carry.pos_z;
    push_data.scale_x = c_carry.scale_x;
    push_data.scale_y = c_carry.scale_y;
    push_data.scale_z = c_carry.scale_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      c_v   <= 1'b0;
      c_cnt <= 2'd0;
    end else begin
      if (s1_ok) begin
        s1_v <= in_valid;
      end
      if (s2_ok) begin
        s2_v <= s1_v;
      end
      if (c_load_ok) begin
        c_v   <= s2_v;
        c_cnt <= 2'd0;
      end else if (c_cnt != 2'd3) begin
        c_cnt <= c_cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ok) begin
      for (int l = 0; l < 3; l++) begin
        s1_whole[l] <= whole[l];
        s1_frac[l]  <= frac16[l];
      end
      s1_carry <= '{pos_x, pos_y, pos_z, scale_x, scale_y, scale_z};
    end
    if (s2_ok) begin
      for (int l = 0; l < 3; l++) begin
        s2_whole[l] <= s1_whole[l];
        s2_prod[l]  <= PW'(s1_whole[l]) * PW'(RECIP_360);
        s2_frac[l]  <= s1_frac[l];
      end
      s2_carry <= s1_carry;
    end
    if (c_load_ok) begin
      for (int l = 0; l < 3; l++) begin
        c_x[l] <= CORDIC_GAIN;
        c_y[l] <= '0;
        c_z[l] <= zl[l];
      end
      c_neg   <= nl;
      c_carry <= s2_carry;
    end else if (c_v && c_cnt != 2'd3) begin
      for (int l = 0; l < 3; l++) begin
        c_x[l] <= nx[l];
        c_y[l] <= ny[l];
        c_z[l] <= nz[l];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/trs_queue.sv
// ----------------------------------------------------------------------------
// trs_queue
// four-word queue between the cordic front and the matrix back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trs_queue import trs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  trs_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output trs_entry_t head
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  trs_entry_t    slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign full       = (count == (AW + 1)'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/trs_back.sv
// ----------------------------------------------------------------------------
// trs_back
// matrix product, scaling and saturation, one row per cycle while not stalled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trs_back import trs_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  input  trs_entry_t             head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             row_index,
  output logic signed [IN_W-1:0] col0,
  output logic signed [IN_W-1:0] col1,
  output logic signed [IN_W-1:0] col2,
  output logic signed [IN_W-1:0] col3,
  output logic                   last_row
);

  localparam int TW = FRAC_BITS + 3;
  localparam int PW = 2 * TW;
  localparam int QW = PW + 1;
  localparam int SW = TW + IN_W;

  localparam logic signed [TW-1:0] ONE    = TW'(1) << FRAC_BITS;
  localparam logic signed [CW-1:0] HALF_C = CW'(1) << (29 - FRAC_BITS);
  localparam logic signed [PW-1:0] HALF_P = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [QW-1:0] HALF_Q = QW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] HALF_S = SW'(1) << (FRAC_BITS - 1);
  localparam logic signed [63:0]   SAT_HI = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0]   SAT_LO = -SAT_HI - 64'sd1;

  function automatic logic signed [TW-1:0] trig(input logic signed [CW-1:0] v,
                                                input logic n);
    logic signed [CW-1:0] r;
    r    = (v + HALF_C) >>> (30 - FRAC_BITS);
    trig = n ? TW'(-r) : TW'(r);
  endfunction

  function automatic logic [IN_W-1:0] sat(input logic signed [63:0] v);
    logic signed [63:0] s;
    s = v;
    if (v > SAT_HI) begin
      s = SAT_HI;
    end else if (v < SAT_LO) begin
      s = SAT_LO;
    end
    sat = s[IN_W-1:0];
  endfunction

  logic en, issue;
  row_t rc;

  logic signed [TW-1:0] cx, sx, cy, sy, cz, sz;
  logic signed [TW-1:0] a0, b0, a2, b2, t1_sel;
  logic signed [IN_W-1:0] pos_sel;

  // stage 1: operands for the rx*ry row
  logic                   b1_v;
  row_t                   b1_row;
  logic signed [TW-1:0]   b1_a0, b1_b0, b1_a2, b1_b2, b1_t1, b1_cz, b1_sz;
  logic signed [IN_W-1:0] b1_sc [3];
  logic signed [IN_W-1:0] b1_pos;

  // stage 2: rx*ry products
  logic                   b2_v;
  row_t                   b2_row;
  logic signed [PW-1:0]   b2_p0, b2_p2;
  logic signed [TW-1:0]   b2_t1, b2_cz, b2_sz;
  logic signed [IN_W-1:0] b2_sc [3];
  logic signed [IN_W-1:0] b2_pos;

  // stage 3: products with rz
  logic                   b3_v;
  row_t                   b3_row;
  logic signed [PW-1:0]   b3_q00, b3_q01, b3_q10, b3_q11;
  logic signed [TW-1:0]   b3_t2;
  logic signed [IN_W-1:0] b3_sc [3];
  logic signed [IN_W-1:0] b3_pos;

  // stage 4: scaled elements
  logic                   b4_v;
  row_t                   b4_row;
  logic signed [SW-1:0]   b4_s [3];
  logic signed [IN_W-1:0] b4_pos;

  logic signed [TW-1:0] t0_r, t2_r, r0_r, r1_r;
  logic signed [QW-1:0] sum0, sum1;
  logic signed [SW-1:0] m_r [3];

  assign en    = !out_valid || !out_stall;
  assign issue = en && head_valid;
  assign pop   = issue && (rc == ROW_3);

  always_comb begin
    cx = trig(head.cos_x, head.neg[0]);
    sx = trig(head.sin_x, head.neg[0]);
    cy = trig(head.cos_y, head.neg[1]);
    sy = trig(head.sin_y, head.neg[1]);
    cz = trig(head.cos_z, head.neg[2]);
    sz = trig(head.sin_z, head.neg[2]);
    case (rc)
      ROW_0: begin
        a0 = cy;  b0 = ONE; a2 = sy; b2 = ONE; t1_sel = '0;
        pos_sel = head.pos_x;
      end
      ROW_1: begin
        a0 = -sx; b0 = sy;  a2 = sx; b2 = cy;  t1_sel = cx;
        pos_sel = head.pos_y;
      end
      ROW_2: begin
        a0 = -cx; b0 = sy;  a2 = cx; b2 = cy;  t1_sel = -sx;
        pos_sel = head.pos_z;
      end
      default: begin
        a0 = '0;  b0 = '0;  a2 = '0; b2 = '0;  t1_sel = '0;
        pos_sel = '0;
      end
    endcase
  end

  always_comb begin
    t0_r = TW'((b2_p0 + HALF_P) >>> FRAC_BITS);
    t2_r = TW'((b2_p2 + HALF_P) >>> FRAC_BITS);
    sum0 = QW'(b3_q00) - QW'(b3_q01);
    sum1 = QW'(b3_q10) + QW'(b3_q11);
    r0_r = TW'((sum0 + HALF_Q) >>> FRAC_BITS);
    r1_r = TW'((sum1 + HALF_Q) >>> FRAC_BITS);
    for (int j = 0; j < 3; j++) begin
      m_r[j] = (b4_s[j] + HALF_S) >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rc        <= ROW_0;
      b1_v      <= 1'b0;
      b2_v      <= 1'b0;
      b3_v      <= 1'b0;
      b4_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      if (issue) begin
        rc <= row_t'(rc + 2'd1);
      end
      b1_v      <= issue;
      b2_v      <= b1_v;
      b3_v      <= b2_v;
      b4_v      <= b3_v;
      out_valid <= b4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_row   <= rc;
      b1_a0    <= a0;
      b1_b0    <= b0;
      b1_a2    <= a2;
      b1_b2    <= b2;
      b1_t1    <= t1_sel;
      b1_cz    <= cz;
      b1_sz    <= sz;
      b1_sc[0] <= head.scale_x;
      b1_sc[1] <= head.scale_y;
      b1_sc[2] <= head.scale_z;
      b1_pos   <= pos_sel;

      b2_row <= b1_row;
      b2_p0  <= b1_a0 * b1_b0;
      b2_p2  <= b1_a2 * b1_b2;
      b2_t1  <= b1_t1;
      b2_cz  <= b1_cz;
      b2_sz  <= b1_sz;
      b2_sc  <= b1_sc;
      b2_pos <= b1_pos;

      b3_row <= b2_row;
      b3_q00 <= t0_r * b2_cz;
      b3_q01 <= b2_t1 * b2_sz;
      b3_q10 <= t0_r * b2_sz;
      b3_q11 <= b2_t1 * b2_cz;
      b3_t2  <= t2_r;
      b3_sc  <= b2_sc;
      b3_pos <= b2_pos;

      b4_row  <= b3_row;
      b4_s[0] <= r0_r * b3_sc[0];
      b4_s[1] <= r1_r * b3_sc[1];
      b4_s[2] <= b3_t2 * b3_sc[2];
      b4_pos  <= b3_pos;

      row_index <= b4_row;
      last_row  <= (b4_row == ROW_3);
      if (b4_row == ROW_3) begin
        col0 <= '0;
        col1 <= '0;
        col2 <= '0;
        col3 <= sat(64'(ONE));
      end else begin
        col0 <= sat(64'(m_r[0]));
        col1 <= sat(64'(m_r[1]));
        col2 <= sat(64'(m_r[2]));
        col3 <= sat(64'(b4_pos));
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/trs_transform_matrix_builder.sv
// ----------------------------------------------------------------------------
// trs_transform_matrix_builder
// builds the 4x4 model matrix T*Rx*Ry*Rz*S; while not stalled, one row word per cycle
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | in_valid / in_stall | pos_x..z, angle_x..z, scale_x..z
//  out     | out_valid/out_stall | row_index, col0..col3, last_row
//
//  the transform rate is set by the cordic stepping 4 of its 16
//  iterations per cycle and by the four output rows per transform
//  first row word passes s1, s2, cordic, queue, b1..b4 and output regs
//  reset clears all valid flags and the queue; no clearing pass
//  a four-deep queue lets the front keep taking words while rows are stalled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trs_transform_matrix_builder import trs_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [IN_W-1:0] pos_x,
  input  logic signed [IN_W-1:0] pos_y,
  input  logic signed [IN_W-1:0] pos_z,
  input  logic signed [IN_W-1:0] angle_x,
  input  logic signed [IN_W-1:0] angle_y,
  input  logic signed [IN_W-1:0] angle_z,
  input  logic signed [IN_W-1:0] scale_x,
  input  logic signed [IN_W-1:0] scale_y,
  input  logic signed [IN_W-1:0] scale_z,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             row_index,
  output logic signed [IN_W-1:0] col0,
  output logic signed [IN_W-1:0] col1,
  output logic signed [IN_W-1:0] col2,
  output logic signed [IN_W-1:0] col3,
  output logic                   last_row
);

  logic       push, q_full, pop, head_valid;
  trs_entry_t push_data, head;

  trs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .angle_x   (angle_x),
    .angle_y   (angle_y),
    .angle_z   (angle_z),
    .scale_x   (scale_x),
    .scale_y   (scale_y),
    .scale_z   (scale_z),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  trs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  trs_back #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .row_index  (row_index),
    .col0       (col0),
    .col1       (col1),
    .col2       (col2),
    .col3       (col3),
    .last_row   (last_row)
  );

`ifndef SYNTHESIS
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_row == (row_index == ROW_3)))
    else $error("last_row does not match row_index");

  a_row_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && $past(out_valid && !out_stall && !last_row))
      |-> (row_index == $past(row_index) + 2'd1))
    else $error("rows out of order");

  a_bottom_row: assert property (@(posedge clk) disable iff (rst)
    (out_valid && row_index == ROW_3) |-> (col0 == 0 && col1 == 0 && col2 == 0))
    else $error("bottom row not zero");
`endif

endmodule

`default_nettype wire
